FILE: rtl/core/mads_pkg.sv
package mads_pkg;

  localparam int VALUE_W  = 32;
  localparam int CNT_W    = 31;
  localparam int ACC_W    = 33;
  localparam int MASK_W   = 4;
  localparam int AXIS_W   = 2;
  localparam int AXES_DEF = 4;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    FN_LOAD   = 2'd0,
    FN_START  = 2'd1,
    FN_TICK   = 2'd2,
    FN_SETPOS = 2'd3
  } func_t;

  // per-word commands broadcast from control to every axis
  typedef struct packed {
    logic                      load;
    logic                      start;
    logic                      tick;
    logic                      setpos;
    logic [AXIS_W-1:0]         axis;
    logic signed [VALUE_W-1:0] value;
    logic [CNT_W-1:0]          longest;
    logic signed [ACC_W-1:0]   preset;
  } mads_cmd_t;

  // block status kept by control
  typedef struct packed {
    logic             active;
    logic [CNT_W-1:0] longest;
    logic [CNT_W-1:0] ticks;
  } mads_stat_t;

endpackage

FILE: rtl/core/mads_if.sv
interface mads_in_if import mads_pkg::*; ();
  logic                      valid;
  logic                      ready;
  func_t                     func;
  logic [AXIS_W-1:0]         axis;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, func, axis, value, input ready);
  modport sink   (input valid, func, axis, value, output ready);
endinterface

interface mads_out_if import mads_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [MASK_W-1:0]         step_mask;
  logic [MASK_W-1:0]         dir_mask;
  logic                      block_done;
  logic                      busy_res;
  logic signed [VALUE_W-1:0] position_out;

  modport source (output valid, step_mask, dir_mask, block_done, busy_res, position_out,
                  input ready);
  modport sink   (input valid, step_mask, dir_mask, block_done, busy_res, position_out,
                  output ready);
endinterface

FILE: rtl/core/mads_axis.sv
module mads_axis
  import mads_pkg::*;
#(
  parameter int AXIS_ID = 0
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  mads_cmd_t                 cmd,
  output logic [CNT_W-1:0]          start_cnt,
  output logic                      step,
  output logic                      neg_nxt,
  output logic signed [VALUE_W-1:0] pos_nxt
);

  logic signed [VALUE_W-1:0] target_r, target_nxt;
  logic signed [VALUE_W-1:0] pos_r;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic                      neg_r;
  logic                      sel;
  logic signed [ACC_W-1:0]   delta;
  logic [ACC_W-1:0]          mag;
  logic                      start_neg;
  logic signed [ACC_W-1:0]   sum;

  assign sel = (int'(cmd.axis) == AXIS_ID);

  // delta to target, direction and saturated step count for a block start
  always_comb begin
    delta     = ACC_W'(target_r) - ACC_W'(pos_r);
    start_neg = delta[ACC_W-1] || (delta == '0);
    mag       = delta[ACC_W-1] ? (ACC_W'(0) - delta) : delta;
    start_cnt = (mag > ACC_W'(CNT_MAX)) ? CNT_MAX : mag[CNT_W-1:0];
  end

  // dda accumulate and overflow test
  always_comb begin
    sum  = acc_r + ACC_W'(cnt_r);
    step = cmd.tick && !sum[ACC_W-1] && (sum != '0);
  end

  // next state
  always_comb begin
    target_nxt = target_r;
    pos_nxt    = pos_r;
    cnt_nxt    = cnt_r;
    acc_nxt    = acc_r;
    neg_nxt    = neg_r;
    if (cmd.load && sel) begin
      target_nxt = cmd.value;
    end
    if (cmd.setpos && sel) begin
      pos_nxt = cmd.value;
    end
    if (cmd.start) begin
      cnt_nxt = start_cnt;
      neg_nxt = start_neg;
      acc_nxt = cmd.preset;
    end
    if (cmd.tick) begin
      if (step) begin
        acc_nxt = sum - ACC_W'(cmd.longest);
        pos_nxt = neg_r ? (pos_r - VALUE_W'(1)) : (pos_r + VALUE_W'(1));
      end else begin
        acc_nxt = sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
      pos_r    <= '0;
      cnt_r    <= '0;
      acc_r    <= '0;
      neg_r    <= 1'b0;
    end else begin
      target_r <= target_nxt;
      pos_r    <= pos_nxt;
      cnt_r    <= cnt_nxt;
      acc_r    <= acc_nxt;
      neg_r    <= neg_nxt;
    end
  end

endmodule

FILE: rtl/core/mads_ctrl.sv
module mads_ctrl
  import mads_pkg::*;
#(
  parameter int AXES = AXES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      go,
  input  func_t                     func,
  input  logic [AXIS_W-1:0]         axis,
  input  logic signed [VALUE_W-1:0] value,
  input  logic [CNT_W-1:0]          start_cnt [AXES],
  output mads_cmd_t                 cmd,
  output mads_stat_t                stat,
  output logic                      active_nxt,
  output logic                      done
);

  logic             active_r;
  logic [CNT_W-1:0] longest_r, longest_nxt;
  logic [CNT_W-1:0] ticks_r, ticks_nxt;
  logic [CNT_W-1:0] lmax;
  logic [CNT_W-1:0] tick_cnt;
  logic             is_load, is_start, is_tick, is_setpos;
  logic             start_en, tick_en;

  // function decode
  always_comb begin
    is_load   = 1'b0;
    is_start  = 1'b0;
    is_tick   = 1'b0;
    is_setpos = 1'b0;
    unique case (func)
      FN_LOAD:   is_load   = 1'b1;
      FN_START:  is_start  = 1'b1;
      FN_TICK:   is_tick   = 1'b1;
      FN_SETPOS: is_setpos = 1'b1;
      default:   is_load   = 1'b0;
    endcase
  end

  assign start_en = go && is_start && !active_r;
  assign tick_en  = go && is_tick && active_r;

  // block length: longest axis count, never below one
  always_comb begin
    lmax = CNT_W'(1);
    for (int i = 0; i < AXES; i++) begin
      if (start_cnt[i] > lmax) lmax = start_cnt[i];
    end
  end

  // block progress
  always_comb begin
    tick_cnt    = ticks_r + CNT_W'(1);
    longest_nxt = longest_r;
    ticks_nxt   = ticks_r;
    active_nxt  = active_r;
    done        = 1'b0;
    if (start_en) begin
      longest_nxt = lmax;
      ticks_nxt   = '0;
      active_nxt  = 1'b1;
    end else if (tick_en) begin
      if (tick_cnt >= longest_r) begin
        ticks_nxt  = '0;
        active_nxt = 1'b0;
        done       = 1'b1;
      end else begin
        ticks_nxt = tick_cnt;
      end
    end
  end

  always_comb begin
    cmd.load    = go && is_load;
    cmd.start   = start_en;
    cmd.tick    = tick_en;
    cmd.setpos  = go && is_setpos;
    cmd.axis    = axis;
    cmd.value   = value;
    cmd.longest = longest_r;
    cmd.preset  = ACC_W'(0) - ACC_W'(lmax >> 1);
  end

  assign stat.active  = active_r;
  assign stat.longest = longest_r;
  assign stat.ticks   = ticks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      longest_r <= CNT_W'(1);
      ticks_r   <= '0;
    end else begin
      active_r  <= active_nxt;
      longest_r <= longest_nxt;
      ticks_r   <= ticks_nxt;
    end
  end

endmodule

FILE: rtl/core/multi_axis_dda_step_generator.sv
// channel  dir  role    payload
// in_ch    in   sink    func, axis, value
// out_ch   out  source  step_mask, dir_mask, block_done, busy_res, position_out
//
// one word per clock unless out_ch stalls; a taken word enters the input register,
// then one pass of axis adders carries its result into the result register
// synchronous active-low reset: positions, targets, counts cleared, block length one
// a stalled result holds the result register; an empty input register still takes one
// more word, after which in_ch.ready stays low until out_ch.ready returns
module multi_axis_dda_step_generator
  import mads_pkg::*;
#(
  parameter int AXES = AXES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  mads_in_if.sink    in_ch,
  mads_out_if.source out_ch
);

  logic                      in_v_r;
  func_t                     func_r;
  logic [AXIS_W-1:0]         axis_r;
  logic signed [VALUE_W-1:0] value_r;
  logic                      go;

  logic                      out_v_r;
  logic [MASK_W-1:0]         step_r;
  logic [MASK_W-1:0]         dir_r;
  logic                      done_r;
  logic                      busy_r;
  logic signed [VALUE_W-1:0] pos_out_r, pos_sel;

  mads_cmd_t                 cmd;
  mads_stat_t                stat;
  logic                      active_nxt;
  logic                      done;
  logic [CNT_W-1:0]          start_cnt [AXES];
  logic                      step_v [AXES];
  logic                      neg_v  [AXES];
  logic signed [VALUE_W-1:0] pos_v  [AXES];
  logic [AXES-1:0]           step_bits, dir_bits;

  assign go          = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || go;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      func_r  <= in_ch.func;
      axis_r  <= in_ch.axis;
      value_r <= in_ch.value;
    end
  end

  mads_ctrl #(.AXES(AXES)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (go),
    .func       (func_r),
    .axis       (axis_r),
    .value      (value_r),
    .start_cnt  (start_cnt),
    .cmd        (cmd),
    .stat       (stat),
    .active_nxt (active_nxt),
    .done       (done)
  );

  for (genvar g = 0; g < AXES; g++) begin : g_axis
    mads_axis #(.AXIS_ID(g)) u_axis (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .start_cnt (start_cnt[g]),
      .step      (step_v[g]),
      .neg_nxt   (neg_v[g]),
      .pos_nxt   (pos_v[g])
    );
  end

  // gather masks and read back the selected axis
  always_comb begin
    pos_sel = '0;
    for (int i = 0; i < AXES; i++) begin
      step_bits[i] = step_v[i];
      dir_bits[i]  = neg_v[i];
      if (int'(axis_r) == i) pos_sel = pos_v[i];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (go) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      step_r    <= MASK_W'(step_bits);
      dir_r     <= MASK_W'(dir_bits);
      done_r    <= done;
      busy_r    <= active_nxt;
      pos_out_r <= pos_sel;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.step_mask    = step_r;
  assign out_ch.dir_mask     = dir_r;
  assign out_ch.block_done   = done_r;
  assign out_ch.busy_res     = busy_r;
  assign out_ch.position_out = pos_out_r;

  // a finishing tick leaves the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && done_r |-> !busy_r)
    else $error("block_done reported with block still busy");

  // tick count stays inside the block length
  a_ticks: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.longest != '0) && (!stat.active || (stat.ticks < stat.longest)))
    else $error("tick count outside block length");

  // input only backs up behind a stalled result
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (in_v_r && out_v_r && !out_ch.ready))
    else $error("input stalled without output stall");

  // a start accepted while idle makes the block busy
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> stat.active)
    else $error("start did not activate block");

endmodule
